>>> design/ycbrgb_pkg.sv
// Package for the 4:2:0 block to RGB converter: payload structs, config struct,
// register indexes and fixed-point constants. No dependencies.
package ycbrgb_pkg;

   localparam int TERM_W = 27;
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   localparam logic signed [17:0] SCALE_RED_CR   = 18'sd91881;
   localparam logic signed [17:0] SCALE_GREEN_CB = -18'sd22553;
   localparam logic signed [17:0] SCALE_GREEN_CR = -18'sd46801;
   localparam logic signed [17:0] SCALE_BLUE_CB  = 18'sd116129;

   localparam logic signed [TERM_W-1:0] CLIP_HIGH = 27'sd16777215;
   localparam logic signed [TERM_W-1:0] CLIP_LOW  = 27'sd65535;

   localparam logic REG_OUTPUT_FORMAT = 1'b0;
   localparam logic REG_SWAP_CHROMA   = 1'b1;

   localparam logic FORMAT_RGB888 = 1'b0;
   localparam logic FORMAT_RGB565 = 1'b1;

   typedef struct packed {
      logic [7:0] luma_top_left;
      logic [7:0] luma_top_right;
      logic [7:0] luma_bottom_left;
      logic [7:0] luma_bottom_right;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
   } req_payload_type;

   typedef struct packed {
      logic [23:0] pixel_top_left;
      logic [23:0] pixel_top_right;
      logic [23:0] pixel_bottom_left;
      logic [23:0] pixel_bottom_right;
   } rsp_payload_type;

   typedef struct packed {
      logic output_format;
      logic swap_chroma;
   } cfg_type;

endpackage

>>> design/ycbcr420_block_to_rgb_top.sv
// Top level of the 4:2:0 block to RGB converter: input register, chroma terms,
// four pixel units and result register. Depends on ycbrgb_pkg, ycbrgb_csr, ycbrgb_pixel.
//
// Usage:
//   req_*: one beat is a 2x2 block (four luma bytes, shared Cb and Cr).
//   rsp_*: one beat is the four packed pixels of that block.
//   Both channels use valid/stall; a beat moves when valid is high and stall low.
//   Registers output_format and swap_chroma sit on the APB-style port at byte
//   addresses 0 and 4; write them only while no block is in flight.
// Timing:
//   Two register stages, input and result. An accepted block passes from the
//   input register to the result register, which drives rsp_. One block per
//   cycle while rsp_ is not stalled, set by the single conversion pass between them.
//   A stall on rsp_ holds the result; the input stage keeps filling, and
//   req_stall rises once both stages are full and the result is still stalled.
// Reset: synchronous; empties both stages and restores output_format = 0,
//   swap_chroma = 1.
module ycbcr420_block_to_rgb_top
   import ycbrgb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_payload_type    req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_payload_type    rsp_payload,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   cfg_type         cfg;
   req_payload_type blk_ff;
   logic            blk_valid_ff;
   rsp_payload_type res_ff, res_in;
   logic            res_valid_ff;
   logic            res_load;
   logic            blk_load;

   logic signed [8:0]        cb, cr;
   logic signed [TERM_W-1:0] red_cr, blue_cb, green;
   logic signed [TERM_W-1:0] r_term, b_term;

   ycbrgb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign res_load  = blk_valid_ff & (~res_valid_ff | ~rsp_stall);
   assign req_stall = blk_valid_ff & ~res_load;
   assign blk_load  = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         if (blk_load)
            blk_valid_ff <= 1'b1;
         else if (res_load)
            blk_valid_ff <= 1'b0;
         if (res_load)
            res_valid_ff <= 1'b1;
         else if (~rsp_stall)
            res_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (blk_load)
         blk_ff <= req_payload;
      if (res_load)
         res_ff <= res_in;
   end

   // value - 128 as two's complement
   assign cb = {~blk_ff.chroma_blue[7], ~blk_ff.chroma_blue[7], blk_ff.chroma_blue[6:0]};
   assign cr = {~blk_ff.chroma_red[7], ~blk_ff.chroma_red[7], blk_ff.chroma_red[6:0]};

   assign red_cr  = TERM_W'(SCALE_RED_CR) * TERM_W'(cr);
   assign blue_cb = TERM_W'(SCALE_BLUE_CB) * TERM_W'(cb);
   assign green   = TERM_W'(SCALE_GREEN_CB) * TERM_W'(cb)
                  + TERM_W'(SCALE_GREEN_CR) * TERM_W'(cr);

   assign r_term = cfg.swap_chroma ? blue_cb : red_cr;
   assign b_term = cfg.swap_chroma ? red_cr : blue_cb;

   ycbrgb_pixel u_px_tl (
      .luma          (blk_ff.luma_top_left),
      .r_term        (r_term),
      .g_term        (green),
      .b_term        (b_term),
      .output_format (cfg.output_format),
      .pixel         (res_in.pixel_top_left)
   );

   ycbrgb_pixel u_px_tr (
      .luma          (blk_ff.luma_top_right),
      .r_term        (r_term),
      .g_term        (green),
      .b_term        (b_term),
      .output_format (cfg.output_format),
      .pixel         (res_in.pixel_top_right)
   );

   ycbrgb_pixel u_px_bl (
      .luma          (blk_ff.luma_bottom_left),
      .r_term        (r_term),
      .g_term        (green),
      .b_term        (b_term),
      .output_format (cfg.output_format),
      .pixel         (res_in.pixel_bottom_left)
   );

   ycbrgb_pixel u_px_br (
      .luma          (blk_ff.luma_bottom_right),
      .r_term        (r_term),
      .g_term        (green),
      .b_term        (b_term),
      .output_format (cfg.output_format),
      .pixel         (res_in.pixel_bottom_right)
   );

   assign rsp_valid   = res_valid_ff;
   assign rsp_payload = res_ff;

endmodule

>>> design/ycbrgb_csr.sv
// APB-style register file holding output_format and swap_chroma.
// Depends on ycbrgb_pkg.
module ycbrgb_csr
   import ycbrgb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready,
   output cfg_type            cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;
   logic    reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_OUTPUT_FORMAT: cfg_in.output_format = pwdata[0];
            REG_SWAP_CHROMA:   cfg_in.swap_chroma   = pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.output_format <= FORMAT_RGB888;
         cfg_ff.swap_chroma   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_idx)
         REG_OUTPUT_FORMAT: prdata[0] = cfg_ff.output_format;
         REG_SWAP_CHROMA:   prdata[0] = cfg_ff.swap_chroma;
         default:           prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> design/ycbrgb_pixel.sv
// One pixel: adds scaled luma to the chroma terms, clips each channel, packs.
// Depends on ycbrgb_pkg.
module ycbrgb_pixel
   import ycbrgb_pkg::*;
(
   input  logic [7:0]               luma,
   input  logic signed [TERM_W-1:0] r_term,
   input  logic signed [TERM_W-1:0] g_term,
   input  logic signed [TERM_W-1:0] b_term,
   input  logic                     output_format,
   output logic [23:0]              pixel
);

   function automatic logic [7:0] clip(input logic signed [TERM_W-1:0] sum);
      logic [7:0] res;
      if (sum > CLIP_HIGH)
         res = 8'hff;
      else if (sum <= CLIP_LOW)
         res = 8'h00;
      else
         res = sum[23:16];
      return res;
   endfunction

   logic signed [TERM_W-1:0] y;
   logic [7:0] r, g, b;

   assign y = {(TERM_W - 24)'(0), luma, 16'h0000};
   assign r = clip(r_term + y);
   assign g = clip(g_term + y);
   assign b = clip(b_term + y);

   always_comb begin
      case (output_format)
         FORMAT_RGB565: pixel = {8'h00, r[7:3], g[7:2], b[7:3]};
         default:       pixel = {r, g, b};
      endcase
   end

endmodule

>>> verif/ycbcr420_block_to_rgb_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for ycbcr420_block_to_rgb_top: corner and random 2x2 blocks under every
// register setting, bursty sender and stalling receiver. Depends on ycbrgb_pkg and the DUT.
module ycbcr420_block_to_rgb_top_test;
   import ycbrgb_pkg::*;

   localparam int RED_FROM_CR    = 91881;
   localparam int GREEN_FROM_CB  = -22553;
   localparam int GREEN_FROM_CR  = -46801;
   localparam int BLUE_FROM_CB   = 116129;
   localparam int LUMA_ONE       = 65536;
   localparam int CHROMA_BIAS    = 128;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int BLOCKS_PER_SET = 170;

   // fields: luma TL, TR, BL, BR, Cb, Cr
   localparam logic [47:0] CORNER_BLOCKS [6] = '{
      48'h0000_0000_8080, 48'hFFFF_FFFF_8080, 48'hFF00_8001_FFFF,
      48'h00FF_0180_0000, 48'hFFFF_0000_FF00, 48'h0000_FFFF_00FF};

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_payload_type    req_payload = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_payload_type    rsp_payload;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [PDATA_W-1:0] pwdata = '0;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   logic            cfg_format = FORMAT_RGB888;
   logic            cfg_swap = 1'b1;
   rsp_payload_type pending_pixels [$];
   int              error_count = 0;
   int              cycle_count = 0;
   int              burst_left = 0;
   int              stall_pct = 0;
   int              stall_phase_left = 0;

   ycbcr420_block_to_rgb_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL ycbcr420_block_to_rgb_top");
         $finish;
      end
   end

   function automatic logic [7:0] saturate_channel(int sum);
      if (sum > 16777215) return 8'hFF;
      if (sum <= 65535) return 8'h00;
      return sum[23:16];
   endfunction

   function automatic logic [23:0] pack_pixel(logic [7:0] luma, int r_term, int g_term,
                                              int b_term);
      int         y;
      logic [7:0] r, g, b;
      y = int'(luma) * LUMA_ONE;
      r = saturate_channel(r_term + y);
      g = saturate_channel(g_term + y);
      b = saturate_channel(b_term + y);
      if (cfg_format == FORMAT_RGB565) return {8'h00, r[7:3], g[7:2], b[7:3]};
      return {r, g, b};
   endfunction

   function automatic rsp_payload_type convert_block(req_payload_type blk);
      int              cb, cr, r_term, g_term, b_term;
      rsp_payload_type px;
      cb = int'(blk.chroma_blue) - CHROMA_BIAS;
      cr = int'(blk.chroma_red) - CHROMA_BIAS;
      g_term = GREEN_FROM_CB * cb + GREEN_FROM_CR * cr;
      if (cfg_swap) begin
         r_term = BLUE_FROM_CB * cb;
         b_term = RED_FROM_CR * cr;
      end else begin
         r_term = RED_FROM_CR * cr;
         b_term = BLUE_FROM_CB * cb;
      end
      px.pixel_top_left     = pack_pixel(blk.luma_top_left, r_term, g_term, b_term);
      px.pixel_top_right    = pack_pixel(blk.luma_top_right, r_term, g_term, b_term);
      px.pixel_bottom_left  = pack_pixel(blk.luma_bottom_left, r_term, g_term, b_term);
      px.pixel_bottom_right = pack_pixel(blk.luma_bottom_right, r_term, g_term, b_term);
      return px;
   endfunction

   // accepted request beats queue their predicted pixels
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         pending_pixels.push_back(convert_block(req_payload));
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected result beat: expected none actual %h", $time, rsp_payload);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_payload.pixel_top_left !== want.pixel_top_left) begin
               $display("%0t: pixel_top_left expected %h actual %h", $time,
                        want.pixel_top_left, rsp_payload.pixel_top_left);
               error_count++;
            end
            if (rsp_payload.pixel_top_right !== want.pixel_top_right) begin
               $display("%0t: pixel_top_right expected %h actual %h", $time,
                        want.pixel_top_right, rsp_payload.pixel_top_right);
               error_count++;
            end
            if (rsp_payload.pixel_bottom_left !== want.pixel_bottom_left) begin
               $display("%0t: pixel_bottom_left expected %h actual %h", $time,
                        want.pixel_bottom_left, rsp_payload.pixel_bottom_left);
               error_count++;
            end
            if (rsp_payload.pixel_bottom_right !== want.pixel_bottom_right) begin
               $display("%0t: pixel_bottom_right expected %h actual %h", $time,
                        want.pixel_bottom_right, rsp_payload.pixel_bottom_right);
               error_count++;
            end
         end
      end
   end

   // receiver backpressure: phases of random length, each with its own stall rate
   always @(posedge clock) begin
      if (stall_phase_left == 0) begin
         stall_phase_left <= $urandom_range(1, 40);
         case ($urandom_range(3))
            0: stall_pct <= 0;
            1: stall_pct <= 25;
            2: stall_pct <= 50;
            default: stall_pct <= 90;
         endcase
      end else begin
         stall_phase_left <= stall_phase_left - 1;
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_block(input req_payload_type blk);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_payload <= blk;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      repeat (2) @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic reg_index, input logic value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_index, 2'b00};
      pwdata <= ($urandom() & 32'hFFFF_FFFE) | value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (reg_index == REG_OUTPUT_FORMAT) cfg_format = value;
      else cfg_swap = value;
      @(posedge clock);
   endtask

   task automatic check_register(input logic reg_index);
      logic [PDATA_W-1:0] want;
      want = (reg_index == REG_OUTPUT_FORMAT) ? PDATA_W'(cfg_format) : PDATA_W'(cfg_swap);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {reg_index, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== want) begin
         $display("%0t: register %0d readback expected %h actual %h", $time, reg_index,
                  want, prdata);
         error_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic format, input logic swap);
      write_register(REG_OUTPUT_FORMAT, format);
      write_register(REG_SWAP_CHROMA, swap);
      check_register(REG_OUTPUT_FORMAT);
      check_register(REG_SWAP_CHROMA);
   endtask

   function automatic logic [7:0] pick_byte(bit near_edge);
      if (!near_edge) return 8'($urandom());
      case ($urandom_range(5))
         0: return 8'h00;
         1: return 8'h01;
         2: return 8'h7F;
         3: return 8'h80;
         4: return 8'hFE;
         default: return 8'hFF;
      endcase
   endfunction

   function automatic req_payload_type random_block();
      req_payload_type blk;
      bit              edge_luma, edge_chroma;
      edge_luma = ($urandom_range(3) == 0);
      edge_chroma = ($urandom_range(3) == 0);
      blk.luma_top_left     = pick_byte(edge_luma);
      blk.luma_top_right    = pick_byte(edge_luma);
      blk.luma_bottom_left  = pick_byte(edge_luma);
      blk.luma_bottom_right = pick_byte(edge_luma);
      blk.chroma_blue       = pick_byte(edge_chroma);
      blk.chroma_red        = pick_byte(edge_chroma);
      return blk;
   endfunction

   task automatic test_reset_values();
      check_register(REG_OUTPUT_FORMAT);
      check_register(REG_SWAP_CHROMA);
   endtask

   task automatic test_corner_blocks();
      for (int setting = 0; setting < 4; setting++) begin
         wait_idle();
         configure(setting[0], setting[1]);
         for (int i = 0; i < 6; i++) send_block(req_payload_type'(CORNER_BLOCKS[i]));
      end
   endtask

   task automatic test_random_streams();
      for (int setting = 0; setting < 6; setting++) begin
         wait_idle();
         if (setting < 4) configure(setting[0], ~setting[1]);
         else configure(1'($urandom()), 1'($urandom()));
         for (int i = 0; i < BLOCKS_PER_SET; i++) send_block(random_block());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_corner_blocks();
      test_random_streams();
      wait_idle();
      if (error_count == 0) begin
         $display("PASS ycbcr420_block_to_rgb_top");
      end else begin
         $display("FAIL ycbcr420_block_to_rgb_top");
      end
      $finish;
   end

endmodule
